/* hdl/pps_pkg.sv */
package pps_pkg;

  // Default sizing of the slot table and of the time counter.
  localparam int unsigned DEF_SLOTS     = 16;
  localparam int unsigned DEF_TIME_BITS = 32;

  // Input operation codes.
  typedef enum logic {
    OP_TICK   = 1'b0,
    OP_ARRIVE = 1'b1
  } op_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_IDLE = 2'd1,
    STAT_BUSY = 2'd2,
    STAT_ZERO = 2'd3
  } status_e;

  // Commands broadcast from the controller to the slot cells.
  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_LOAD   = 3'd1,
    CMD_STAMP  = 3'd2,
    CMD_RUN    = 3'd3,
    CMD_RETIRE = 3'd4
  } cmd_e;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_ARRIVE = 3'd1,
    S_SCAN   = 3'd2,
    S_DECIDE = 3'd3,
    S_EXEC   = 3'd4,
    S_FINISH = 3'd5
  } state_e;

  // One input beat.
  typedef struct packed {
    op_e         operation;
    logic [3:0]  slot;
    logic [7:0]  priority_req;
    logic [15:0] burst;
  } sched_in_t;

  // One result beat.
  typedef struct packed {
    status_e     status;
    logic [3:0]  running_slot;
    logic        preempted;
    logic        finished;
    logic [15:0] turnaround_time;
    logic [15:0] waiting_time;
    logic [15:0] response_time;
  } sched_out_t;

endpackage

/* hdl/pps_cell.sv */
module pps_cell #(
  parameter int unsigned TIME_BITS = pps_pkg::DEF_TIME_BITS,
  parameter int unsigned SLOT_W    = 4,
  parameter int unsigned INDEX     = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pps_pkg::cmd_e        cmd_op_i,
  input  logic                 cmd_hit_i,
  input  logic [7:0]           cmd_prio_i,
  input  logic [15:0]          cmd_burst_i,
  input  logic [TIME_BITS-1:0] cmd_time_i,
  input  logic [15:0]          cmd_resp_i,
  input  logic                 skip_i,
  input  logic                 cand_found_i,
  input  logic [7:0]           cand_prio_i,
  input  logic [TIME_BITS-1:0] cand_stamp_i,
  input  logic [SLOT_W-1:0]    cand_slot_i,
  output logic                 cand_found_o,
  output logic [7:0]           cand_prio_o,
  output logic [TIME_BITS-1:0] cand_stamp_o,
  output logic [SLOT_W-1:0]    cand_slot_o,
  input  logic                 rd_hit_i,
  output logic [7:0]           rd_prio_o,
  output logic [15:0]          rd_remaining_o,
  output logic [15:0]          rd_burst_o,
  output logic [TIME_BITS-1:0] rd_arrival_o,
  output logic                 rd_started_o,
  output logic [15:0]          rd_response_o,
  output logic                 valid_o
);
  import pps_pkg::*;

  logic                 valid_q, valid_d;
  logic                 started_q, started_d;
  logic [7:0]           prio_q, prio_d;
  logic [15:0]          remaining_q, remaining_d;
  logic [15:0]          burst_q, burst_d;
  logic [TIME_BITS-1:0] arrival_q, arrival_d;
  logic [TIME_BITS-1:0] stamp_q, stamp_d;
  logic [15:0]          response_q, response_d;

  logic                 take_self;
  logic                 cand_found_q, cand_found_d;
  logic [7:0]           cand_prio_q, cand_prio_d;
  logic [TIME_BITS-1:0] cand_stamp_q, cand_stamp_d;
  logic [SLOT_W-1:0]    cand_slot_q, cand_slot_d;

  // Apply a command addressed to this slot.
  always_comb begin
    valid_d     = valid_q;
    started_d   = started_q;
    prio_d      = prio_q;
    remaining_d = remaining_q;
    burst_d     = burst_q;
    arrival_d   = arrival_q;
    stamp_d     = stamp_q;
    response_d  = response_q;
    if (cmd_hit_i) begin
      unique case (cmd_op_i)
        CMD_LOAD: begin
          valid_d     = 1'b1;
          started_d   = 1'b0;
          prio_d      = cmd_prio_i;
          remaining_d = cmd_burst_i;
          burst_d     = cmd_burst_i;
          arrival_d   = cmd_time_i;
          stamp_d     = cmd_time_i;
          response_d  = '0;
        end
        CMD_STAMP: begin
          stamp_d = cmd_time_i;
        end
        CMD_RUN: begin
          started_d   = 1'b1;
          response_d  = cmd_resp_i;
          remaining_d = remaining_q - 16'd1;
        end
        CMD_RETIRE: begin
          valid_d     = 1'b0;
          started_d   = 1'b0;
          remaining_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      started_q <= 1'b0;
    end else begin
      valid_q   <= valid_d;
      started_q <= started_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q      <= prio_d;
    remaining_q <= remaining_d;
    burst_q     <= burst_d;
    arrival_q   <= arrival_d;
    stamp_q     <= stamp_d;
    response_q  <= response_d;
  end

  // Ranking step of the scan: the incoming candidate comes from a lower slot,
  // so it keeps its place on a full tie of priority and stamp.
  always_comb begin
    take_self = valid_q && !skip_i &&
                (!cand_found_i || (prio_q < cand_prio_i) ||
                 ((prio_q == cand_prio_i) && (stamp_q < cand_stamp_i)));
    if (take_self) begin
      cand_found_d = 1'b1;
      cand_prio_d  = prio_q;
      cand_stamp_d = stamp_q;
      cand_slot_d  = SLOT_W'(INDEX);
    end else begin
      cand_found_d = cand_found_i;
      cand_prio_d  = cand_prio_i;
      cand_stamp_d = cand_stamp_i;
      cand_slot_d  = cand_slot_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_found_q <= 1'b0;
    end else begin
      cand_found_q <= cand_found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_prio_q  <= cand_prio_d;
    cand_stamp_q <= cand_stamp_d;
    cand_slot_q  <= cand_slot_d;
  end

  assign cand_found_o = cand_found_q;
  assign cand_prio_o  = cand_prio_q;
  assign cand_stamp_o = cand_stamp_q;
  assign cand_slot_o  = cand_slot_q;

  // Read port: fields are gated so that the controller can OR all cells.
  assign rd_prio_o      = rd_hit_i ? prio_q : '0;
  assign rd_remaining_o = rd_hit_i ? remaining_q : '0;
  assign rd_burst_o     = rd_hit_i ? burst_q : '0;
  assign rd_arrival_o   = rd_hit_i ? arrival_q : '0;
  assign rd_started_o   = rd_hit_i & started_q;
  assign rd_response_o  = rd_hit_i ? response_q : '0;
  assign valid_o        = valid_q;

endmodule

/* hdl/preemptive_priority_scheduler.sv */
// Preemptive priority scheduler over a table of SLOTS task slots, advanced one
// time unit per tick beat. Each slot lives in its own cell; on a tick the best
// ready task (lowest priority value, then oldest stamp, then lowest slot) is
// found by passing a candidate along the row of cells, one cell per cycle. A
// tick then passes through the decide, execute and finish states; execute is
// skipped when no task is running or ready. An arrival beat is handled in the
// arrival state alone. One beat is worked on at a time; the next input beat
// is taken while the previous result still waits on the output.
// Every input beat yields exactly one result beat.
module preemptive_priority_scheduler #(
  parameter int unsigned SLOTS     = pps_pkg::DEF_SLOTS,
  parameter int unsigned TIME_BITS = pps_pkg::DEF_TIME_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pps_pkg::sched_in_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pps_pkg::sched_out_t out_data_o
);
  import pps_pkg::*;

  localparam int unsigned SLOT_W = $clog2(SLOTS);

  function automatic logic [15:0] sat16(input logic [TIME_BITS-1:0] v);
    sat16 = (v > TIME_BITS'(16'hFFFF)) ? 16'hFFFF : v[15:0];
  endfunction

  state_e               state_q, state_d;
  sched_in_t            item_q, item_d;
  logic [SLOT_W-1:0]    cnt_q, cnt_d;
  logic [TIME_BITS-1:0] time_q, time_d;
  logic                 run_valid_q, run_valid_d;
  logic [SLOT_W-1:0]    run_slot_q, run_slot_d;
  logic                 have_q, have_d;
  logic                 pre_q, pre_d;
  logic [SLOT_W-1:0]    chosen_q, chosen_d;
  logic [TIME_BITS-1:0] rdiff_q, rdiff_d;
  logic [TIME_BITS-1:0] tat_q, tat_d;
  logic [15:0]          burst_r_q, burst_r_d;
  logic [15:0]          rem_q, rem_d;
  logic                 started_r_q, started_r_d;
  logic [15:0]          resp_r_q, resp_r_d;
  logic                 out_valid_q, out_valid_d;
  sched_out_t           out_q, out_d;

  logic                 in_accept;
  logic                 out_free;
  logic                 run_active;
  logic                 slot_ok;
  logic [SLOT_W-1:0]    item_idx;
  logic                 finish_now;
  logic [15:0]          resp_new;
  logic [TIME_BITS-1:0] burst_ext;

  cmd_e                 cmd_op;
  logic                 cmd_en;
  logic [SLOT_W-1:0]    cmd_slot;
  logic [15:0]          cmd_resp;
  logic [SLOT_W-1:0]    rd_sel;

  logic [SLOTS-1:0]     cmd_hit;
  logic [SLOTS-1:0]     rd_hit;
  logic [SLOTS-1:0]     skip_hit;
  logic [SLOTS-1:0]     valid_vec;

  logic [SLOTS:0]       ch_found;
  logic [7:0]           ch_prio  [SLOTS+1];
  logic [TIME_BITS-1:0] ch_stamp [SLOTS+1];
  logic [SLOT_W-1:0]    ch_slot  [SLOTS+1];

  logic [7:0]           cl_prio      [SLOTS];
  logic [15:0]          cl_remaining [SLOTS];
  logic [15:0]          cl_burst     [SLOTS];
  logic [TIME_BITS-1:0] cl_arrival   [SLOTS];
  logic [SLOTS-1:0]     cl_started;
  logic [15:0]          cl_response  [SLOTS];

  logic [7:0]           rd_prio;
  logic [15:0]          rd_remaining;
  logic [15:0]          rd_burst;
  logic [TIME_BITS-1:0] rd_arrival;
  logic                 rd_started;
  logic [15:0]          rd_response;

  // Handshakes.
  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign item_idx   = SLOT_W'(item_q.slot);
  assign slot_ok    = 32'(item_q.slot) < SLOTS;
  assign run_active = run_valid_q && valid_vec[run_slot_q];
  assign burst_ext  = TIME_BITS'(burst_r_q);
  assign finish_now = (rem_q <= 16'd1);
  assign resp_new   = started_r_q ? resp_r_q : sat16(rdiff_q);

  // Head of the candidate chain carries no task.
  assign ch_found[0] = 1'b0;
  assign ch_prio[0]  = '0;
  assign ch_stamp[0] = '0;
  assign ch_slot[0]  = '0;

  // Row of slot cells.
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    pps_cell #(
      .TIME_BITS (TIME_BITS),
      .SLOT_W    (SLOT_W),
      .INDEX     (g)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .cmd_op_i       (cmd_op),
      .cmd_hit_i      (cmd_hit[g]),
      .cmd_prio_i     (item_q.priority_req),
      .cmd_burst_i    (item_q.burst),
      .cmd_time_i     (time_q),
      .cmd_resp_i     (cmd_resp),
      .skip_i         (skip_hit[g]),
      .cand_found_i   (ch_found[g]),
      .cand_prio_i    (ch_prio[g]),
      .cand_stamp_i   (ch_stamp[g]),
      .cand_slot_i    (ch_slot[g]),
      .cand_found_o   (ch_found[g+1]),
      .cand_prio_o    (ch_prio[g+1]),
      .cand_stamp_o   (ch_stamp[g+1]),
      .cand_slot_o    (ch_slot[g+1]),
      .rd_hit_i       (rd_hit[g]),
      .rd_prio_o      (cl_prio[g]),
      .rd_remaining_o (cl_remaining[g]),
      .rd_burst_o     (cl_burst[g]),
      .rd_arrival_o   (cl_arrival[g]),
      .rd_started_o   (cl_started[g]),
      .rd_response_o  (cl_response[g]),
      .valid_o        (valid_vec[g])
    );
  end

  // Slot decode for commands, reads and the skipped running task.
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      cmd_hit[i]  = cmd_en && (cmd_slot == SLOT_W'(i));
      rd_hit[i]   = (rd_sel == SLOT_W'(i));
      skip_hit[i] = run_active && (run_slot_q == SLOT_W'(i));
    end
  end

  // Gather the selected cell's fields.
  always_comb begin
    rd_prio      = '0;
    rd_remaining = '0;
    rd_burst     = '0;
    rd_arrival   = '0;
    rd_started   = |cl_started;
    rd_response  = '0;
    for (int i = 0; i < SLOTS; i++) begin
      rd_prio      = rd_prio | cl_prio[i];
      rd_remaining = rd_remaining | cl_remaining[i];
      rd_burst     = rd_burst | cl_burst[i];
      rd_arrival   = rd_arrival | cl_arrival[i];
      rd_response  = rd_response | cl_response[i];
    end
  end

  assign rd_sel = (state_q == S_DECIDE) ? run_slot_q : chosen_q;

  // Sequencer: next state, command to the cells and the result beat.
  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    cnt_d       = cnt_q;
    time_d      = time_q;
    run_valid_d = run_valid_q;
    run_slot_d  = run_slot_q;
    have_d      = have_q;
    pre_d       = pre_q;
    chosen_d    = chosen_q;
    rdiff_d     = rdiff_q;
    tat_d       = tat_q;
    burst_r_d   = burst_r_q;
    rem_d       = rem_q;
    started_r_d = started_r_q;
    resp_r_d    = resp_r_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    cmd_op      = CMD_NONE;
    cmd_en      = 1'b0;
    cmd_slot    = '0;
    cmd_resp    = resp_new;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          item_d = in_data_i;
          cnt_d  = '0;
          state_d = (in_data_i.operation == OP_ARRIVE) ? S_ARRIVE : S_SCAN;
        end
      end

      S_ARRIVE: begin
        if (out_free) begin
          out_d        = '0;
          out_d.status = STAT_OK;
          if (item_q.burst == 16'd0) begin
            out_d.status = STAT_ZERO;
          end else if (!slot_ok || valid_vec[item_idx]) begin
            out_d.status = STAT_BUSY;
          end else begin
            cmd_op   = CMD_LOAD;
            cmd_en   = 1'b1;
            cmd_slot = item_idx;
          end
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      S_SCAN: begin
        cnt_d = cnt_q + SLOT_W'(1);
        if (cnt_q == SLOT_W'(SLOTS - 1)) begin
          state_d = S_DECIDE;
        end
      end

      S_DECIDE: begin
        pre_d = 1'b0;
        if (run_active) begin
          have_d   = 1'b1;
          chosen_d = run_slot_q;
          if (ch_found[SLOTS] && (ch_prio[SLOTS] < rd_prio)) begin
            // Preempt: the running task goes back with a fresh stamp.
            cmd_op   = CMD_STAMP;
            cmd_en   = 1'b1;
            cmd_slot = run_slot_q;
            chosen_d = ch_slot[SLOTS];
            pre_d    = 1'b1;
          end
        end else begin
          have_d   = ch_found[SLOTS];
          chosen_d = ch_slot[SLOTS];
        end
        state_d = (run_active || ch_found[SLOTS]) ? S_EXEC : S_FINISH;
      end

      S_EXEC: begin
        rdiff_d     = time_q - rd_arrival;
        tat_d       = time_q + TIME_BITS'(1) - rd_arrival;
        burst_r_d   = rd_burst;
        rem_d       = rd_remaining;
        started_r_d = rd_started;
        resp_r_d    = rd_response;
        state_d     = S_FINISH;
      end

      S_FINISH: begin
        if (out_free) begin
          out_d  = '0;
          time_d = time_q + TIME_BITS'(1);
          if (!have_q) begin
            out_d.status = STAT_IDLE;
            run_valid_d  = 1'b0;
          end else begin
            out_d.status       = STAT_OK;
            out_d.running_slot = 4'(chosen_q);
            out_d.preempted    = pre_q;
            cmd_en             = 1'b1;
            cmd_slot           = chosen_q;
            if (finish_now) begin
              cmd_op                = CMD_RETIRE;
              out_d.finished        = 1'b1;
              out_d.turnaround_time = sat16(tat_q);
              out_d.waiting_time    = (tat_q >= burst_ext) ? sat16(tat_q - burst_ext)
                                                          : 16'd0;
              out_d.response_time   = resp_new;
              run_valid_d           = 1'b0;
              run_slot_d            = '0;
            end else begin
              cmd_op      = CMD_RUN;
              run_valid_d = 1'b1;
              run_slot_d  = chosen_q;
            end
          end
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      time_q      <= '0;
      run_valid_q <= 1'b0;
      run_slot_q  <= '0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      time_q      <= time_d;
      run_valid_q <= run_valid_d;
      run_slot_q  <= run_slot_d;
      have_q      <= have_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    pre_q       <= pre_d;
    chosen_q    <= chosen_d;
    rdiff_q     <= rdiff_d;
    tat_q       <= tat_d;
    burst_r_q   <= burst_r_d;
    rem_q       <= rem_d;
    started_r_q <= started_r_d;
    resp_r_q    <= resp_r_d;
    out_q       <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // In the idle state, a task marked as running always occupies a live slot.
  a_run_slot_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && run_valid_q) |-> valid_vec[run_slot_q])
    else $error("running task refers to an empty slot");

  // A result beat is only produced by the arrival or completion step.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_ARRIVE || $past(state_q) == S_FINISH))
    else $error("result beat raised outside arrival or completion");

  // The scan winner is always a live slot.
  a_scan_winner_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DECIDE && ch_found[SLOTS]) |-> valid_vec[ch_slot[SLOTS]])
    else $error("scan selected an empty slot");

  // Completion is only reported together with a good status.
  a_finish_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.finished) |-> (out_q.status == STAT_OK))
    else $error("completion reported with a bad status");

endmodule
